// ===== rtl/aarm_pkg.sv =====
package aarm_pkg;

   localparam int SQ_STEPS = 31;
   localparam int DIV_STEPS = 31;
   localparam int CORDIC_STEPS = 24;
   localparam int FRONT_DEPTH = SQ_STEPS + DIV_STEPS + 1;
   localparam int CORDIC_START = FRONT_DEPTH - CORDIC_STEPS;
   localparam int LATENCY = FRONT_DEPTH + 6;

   localparam logic signed [32:0] CORDIC_GAIN_INV = 33'sd652032874;
   localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;
   localparam logic [30:0] Q30_ONE_U = 31'd1073741824;
   localparam logic signed [15:0] Q14_ONE = 16'sd16384;

   localparam logic [31:0] ATAN_TABLE [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   typedef enum logic [1:0] {
      QUAD_0,
      QUAD_90,
      QUAD_180,
      QUAD_270
   } quadrant_type;

   typedef struct packed {
      logic [15:0] mag_x;
      logic [15:0] mag_y;
      logic [15:0] mag_z;
      logic        neg_x;
      logic        neg_y;
      logic        neg_z;
      logic        zero;
      logic [15:0] angle;
   } side_type;

   function automatic logic signed [31:0] qround(input logic signed [64:0] p);
      logic signed [64:0] tmp;
      tmp = p + 65'sd536870912;
      return tmp[61:30];
   endfunction

   function automatic logic signed [32:0] qround_wide(input logic signed [64:0] p);
      logic signed [64:0] tmp;
      tmp = p + 65'sd536870912;
      return tmp[62:30];
   endfunction

   function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
      logic signed [34:0] tmp;
      logic signed [18:0] r;
      tmp = 35'(v) + 35'sd32768;
      r = tmp[34:16];
      if (r > 19'sd16384) begin
         return Q14_ONE;
      end else if (r < -19'sd16384) begin
         return -Q14_ONE;
      end
      return r[15:0];
   endfunction

endpackage

// ===== rtl/axis_angle_rotation_matrix_unit.sv =====
// Channel   Ports                                Handshake
// request   req_axis_x/y/z, req_angle            start high while busy low
// response  rsp_m00 .. rsp_m22, rsp_zero_axis    rsp_valid, one cycle
//
// rsp_valid for a transfer is raised after the square root, divider and product
// stages; one item may enter every cycle. The latency is set by the 31-step
// square root and the 31-step divider, each one stage per result bit.
// Reset clears only the valid bits of the stages. busy is always low and
// nothing in the pipeline ever stalls.
module axis_angle_rotation_matrix_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_axis_x,
   input  logic signed [15:0] req_axis_y,
   input  logic signed [15:0] req_axis_z,
   input  logic        [15:0] req_angle,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_m00,
   output logic signed [15:0] rsp_m10,
   output logic signed [15:0] rsp_m20,
   output logic signed [15:0] rsp_m01,
   output logic signed [15:0] rsp_m11,
   output logic signed [15:0] rsp_m21,
   output logic signed [15:0] rsp_m02,
   output logic signed [15:0] rsp_m12,
   output logic signed [15:0] rsp_m22,
   output logic               rsp_zero_axis
);
   import aarm_pkg::*;

   logic     vld_ff [0:LATENCY-1];
   side_type side_ff [0:FRONT_DEPTH];

   logic [61:0] sq_v_ff [0:SQ_STEPS];
   logic [61:0] sq_r_ff [0:SQ_STEPS];

   logic [30:0] dv_n_ff [0:DIV_STEPS];
   logic [61:0] dv_rem_ff [0:DIV_STEPS][3];
   logic [30:0] dv_q_ff [0:DIV_STEPS][3];

   logic signed [32:0] co_x_ff [0:CORDIC_STEPS];
   logic signed [32:0] co_y_ff [0:CORDIC_STEPS];
   logic signed [32:0] co_z_ff [0:CORDIC_STEPS];

   side_type    side_in;
   logic [31:0] sum_sq_in;

   assign busy = 1'b0;

   always_comb begin
      side_in.neg_x = req_axis_x[15];
      side_in.neg_y = req_axis_y[15];
      side_in.neg_z = req_axis_z[15];
      side_in.mag_x = req_axis_x[15] ? 16'(-req_axis_x) : req_axis_x;
      side_in.mag_y = req_axis_y[15] ? 16'(-req_axis_y) : req_axis_y;
      side_in.mag_z = req_axis_z[15] ? 16'(-req_axis_z) : req_axis_z;
      side_in.angle = req_angle;
      sum_sq_in = 32'(side_in.mag_x) * 32'(side_in.mag_x)
                + 32'(side_in.mag_y) * 32'(side_in.mag_y)
                + 32'(side_in.mag_z) * 32'(side_in.mag_z);
      side_in.zero = (sum_sq_in == 32'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LATENCY; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= start & ~busy;
         for (int i = 1; i < LATENCY; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      sq_v_ff[0] <= {2'b0, sum_sq_in, 28'b0};
      sq_r_ff[0] <= '0;
      for (int i = 1; i <= FRONT_DEPTH; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      localparam logic [61:0] BIT = 62'd1 << (2 * (SQ_STEPS - 1 - k));
      logic [61:0] trial;
      logic [61:0] v_in;
      logic [61:0] r_in;
      always_comb begin
         trial = sq_r_ff[k] + BIT;
         if (sq_v_ff[k] >= trial) begin
            v_in = sq_v_ff[k] - trial;
            r_in = (sq_r_ff[k] >> 1) + BIT;
         end else begin
            v_in = sq_v_ff[k];
            r_in = sq_r_ff[k] >> 1;
         end
      end
      always_ff @(posedge clock) begin
         sq_v_ff[k+1] <= v_in;
         sq_r_ff[k+1] <= r_in;
      end
   end

   logic [30:0] norm;
   logic [61:0] rem_init [3];
   logic [15:0] mags [3];

   always_comb begin
      norm = sq_r_ff[SQ_STEPS][30:0];
      mags[0] = side_ff[SQ_STEPS].mag_x;
      mags[1] = side_ff[SQ_STEPS].mag_y;
      mags[2] = side_ff[SQ_STEPS].mag_z;
      for (int c = 0; c < 3; c++) begin
         rem_init[c] = {2'b0, mags[c], 44'b0} + {32'b0, norm[30:1]};
      end
   end

   always_ff @(posedge clock) begin
      dv_n_ff[0] <= norm;
      for (int c = 0; c < 3; c++) begin
         dv_rem_ff[0][c] <= rem_init[c];
         dv_q_ff[0][c] <= '0;
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      localparam int SH = DIV_STEPS - 1 - j;
      logic [61:0] dsr;
      logic [61:0] rem_in [3];
      logic [30:0] q_in [3];
      always_comb begin
         dsr = {31'b0, dv_n_ff[j]} << SH;
         for (int c = 0; c < 3; c++) begin
            if (dv_rem_ff[j][c] >= dsr) begin
               rem_in[c] = dv_rem_ff[j][c] - dsr;
               q_in[c] = {dv_q_ff[j][c][29:0], 1'b1};
            end else begin
               rem_in[c] = dv_rem_ff[j][c];
               q_in[c] = {dv_q_ff[j][c][29:0], 1'b0};
            end
         end
      end
      always_ff @(posedge clock) begin
         dv_n_ff[j+1] <= dv_n_ff[j];
         for (int c = 0; c < 3; c++) begin
            dv_rem_ff[j+1][c] <= rem_in[c];
            dv_q_ff[j+1][c] <= q_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      co_x_ff[0] <= CORDIC_GAIN_INV;
      co_y_ff[0] <= '0;
      co_z_ff[0] <= $signed({3'b0, side_ff[CORDIC_START-1].angle[13:0], 16'b0});
   end

   for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
      logic signed [32:0] atan;
      logic signed [32:0] x_in;
      logic signed [32:0] y_in;
      logic signed [32:0] z_in;
      always_comb begin
         atan = $signed({1'b0, ATAN_TABLE[j]});
         if (!co_z_ff[j][32]) begin
            x_in = co_x_ff[j] - (co_y_ff[j] >>> j);
            y_in = co_y_ff[j] + (co_x_ff[j] >>> j);
            z_in = co_z_ff[j] - atan;
         end else begin
            x_in = co_x_ff[j] + (co_y_ff[j] >>> j);
            y_in = co_y_ff[j] - (co_x_ff[j] >>> j);
            z_in = co_z_ff[j] + atan;
         end
      end
      always_ff @(posedge clock) begin
         co_x_ff[j+1] <= x_in;
         co_y_ff[j+1] <= y_in;
         co_z_ff[j+1] <= z_in;
      end
   end

   // Sine, cosine and unit axis.
   logic signed [32:0] cos_raw;
   logic signed [32:0] sin_raw;
   logic signed [31:0] cs_in;
   logic signed [31:0] sn_in;
   logic signed [32:0] t_in;
   logic signed [31:0] u_in [3];
   logic [30:0]        qclip;
   logic               negs [3];
   side_type           side_end;

   logic signed [31:0] cs_a_ff, sn_a_ff;
   logic signed [32:0] t_a_ff;
   logic signed [31:0] u_a_ff [3];
   logic               zero_a_ff;

   always_comb begin
      side_end = side_ff[FRONT_DEPTH];
      unique case (quadrant_type'(side_end.angle[15:14]))
         QUAD_0: begin
            cos_raw = co_x_ff[CORDIC_STEPS];
            sin_raw = co_y_ff[CORDIC_STEPS];
         end
         QUAD_90: begin
            cos_raw = -co_y_ff[CORDIC_STEPS];
            sin_raw = co_x_ff[CORDIC_STEPS];
         end
         QUAD_180: begin
            cos_raw = -co_x_ff[CORDIC_STEPS];
            sin_raw = -co_y_ff[CORDIC_STEPS];
         end
         default: begin
            cos_raw = co_y_ff[CORDIC_STEPS];
            sin_raw = -co_x_ff[CORDIC_STEPS];
         end
      endcase
      if (cos_raw > 33'(Q30_ONE)) begin
         cs_in = Q30_ONE;
      end else if (cos_raw < -33'(Q30_ONE)) begin
         cs_in = -Q30_ONE;
      end else begin
         cs_in = cos_raw[31:0];
      end
      if (sin_raw > 33'(Q30_ONE)) begin
         sn_in = Q30_ONE;
      end else if (sin_raw < -33'(Q30_ONE)) begin
         sn_in = -Q30_ONE;
      end else begin
         sn_in = sin_raw[31:0];
      end
      t_in = 33'(Q30_ONE) - 33'(cs_in);
      negs[0] = side_end.neg_x;
      negs[1] = side_end.neg_y;
      negs[2] = side_end.neg_z;
      for (int c = 0; c < 3; c++) begin
         qclip = (dv_q_ff[DIV_STEPS][c] > Q30_ONE_U) ? Q30_ONE_U : dv_q_ff[DIV_STEPS][c];
         u_in[c] = negs[c] ? -$signed({1'b0, qclip}) : $signed({1'b0, qclip});
      end
   end

   always_ff @(posedge clock) begin
      cs_a_ff <= cs_in;
      sn_a_ff <= sn_in;
      t_a_ff <= t_in;
      zero_a_ff <= side_end.zero;
      for (int c = 0; c < 3; c++) begin
         u_a_ff[c] <= u_in[c];
      end
   end

   // Pair products of the axis and sine products.
   logic signed [63:0] p_uu_b_ff [6];
   logic signed [63:0] p_su_b_ff [3];
   logic signed [31:0] cs_b_ff;
   logic signed [32:0] t_b_ff;
   logic               zero_b_ff;

   always_ff @(posedge clock) begin
      p_uu_b_ff[0] <= u_a_ff[0] * u_a_ff[0];
      p_uu_b_ff[1] <= u_a_ff[1] * u_a_ff[1];
      p_uu_b_ff[2] <= u_a_ff[2] * u_a_ff[2];
      p_uu_b_ff[3] <= u_a_ff[0] * u_a_ff[1];
      p_uu_b_ff[4] <= u_a_ff[0] * u_a_ff[2];
      p_uu_b_ff[5] <= u_a_ff[1] * u_a_ff[2];
      for (int c = 0; c < 3; c++) begin
         p_su_b_ff[c] <= sn_a_ff * u_a_ff[c];
      end
      cs_b_ff <= cs_a_ff;
      t_b_ff <= t_a_ff;
      zero_b_ff <= zero_a_ff;
   end

   logic signed [31:0] uu_c_ff [6];
   logic signed [31:0] su_c_ff [3];
   logic signed [31:0] cs_c_ff;
   logic signed [32:0] t_c_ff;
   logic               zero_c_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 6; i++) begin
         uu_c_ff[i] <= qround(65'(p_uu_b_ff[i]));
      end
      for (int c = 0; c < 3; c++) begin
         su_c_ff[c] <= qround(65'(p_su_b_ff[c]));
      end
      cs_c_ff <= cs_b_ff;
      t_c_ff <= t_b_ff;
      zero_c_ff <= zero_b_ff;
   end

   logic signed [64:0] p_tuu_d_ff [6];
   logic signed [31:0] su_d_ff [3];
   logic signed [31:0] cs_d_ff;
   logic               zero_d_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 6; i++) begin
         p_tuu_d_ff[i] <= 65'(t_c_ff) * 65'(uu_c_ff[i]);
      end
      su_d_ff <= su_c_ff;
      cs_d_ff <= cs_c_ff;
      zero_d_ff <= zero_c_ff;
   end

   logic signed [32:0] tuu_e_ff [6];
   logic signed [31:0] su_e_ff [3];
   logic signed [31:0] cs_e_ff;
   logic               zero_e_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 6; i++) begin
         tuu_e_ff[i] <= qround_wide(p_tuu_d_ff[i]);
      end
      su_e_ff <= su_d_ff;
      cs_e_ff <= cs_d_ff;
      zero_e_ff <= zero_d_ff;
   end

   // Rodrigues sums, rounding to Q2.14 and the zero axis override.
   logic signed [15:0] m_in [9];
   logic signed [15:0] m_ff [9];
   logic               zero_ff;
   logic               rsp_valid_ff;

   always_comb begin
      m_in[0] = to_q14(34'(cs_e_ff) + 34'(tuu_e_ff[0]));
      m_in[1] = to_q14(34'(tuu_e_ff[3]) - 34'(su_e_ff[2]));
      m_in[2] = to_q14(34'(tuu_e_ff[4]) + 34'(su_e_ff[1]));
      m_in[3] = to_q14(34'(tuu_e_ff[3]) + 34'(su_e_ff[2]));
      m_in[4] = to_q14(34'(cs_e_ff) + 34'(tuu_e_ff[1]));
      m_in[5] = to_q14(34'(tuu_e_ff[5]) - 34'(su_e_ff[0]));
      m_in[6] = to_q14(34'(tuu_e_ff[4]) - 34'(su_e_ff[1]));
      m_in[7] = to_q14(34'(tuu_e_ff[5]) + 34'(su_e_ff[0]));
      m_in[8] = to_q14(34'(cs_e_ff) + 34'(tuu_e_ff[2]));
      if (zero_e_ff) begin
         for (int i = 0; i < 9; i++) begin
            m_in[i] = '0;
         end
         m_in[0] = Q14_ONE;
         m_in[4] = Q14_ONE;
         m_in[8] = Q14_ONE;
      end
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in;
      zero_ff <= zero_e_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[LATENCY-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_m00 = m_ff[0];
   assign rsp_m10 = m_ff[1];
   assign rsp_m20 = m_ff[2];
   assign rsp_m01 = m_ff[3];
   assign rsp_m11 = m_ff[4];
   assign rsp_m21 = m_ff[5];
   assign rsp_m02 = m_ff[6];
   assign rsp_m12 = m_ff[7];
   assign rsp_m22 = m_ff[8];
   assign rsp_zero_axis = zero_ff;

endmodule
